// ===== src/ssr_pkg.sv =====
`timescale 1ns / 1ps

package ssr_pkg;

  localparam int MAX_TARGET = 8;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int PAT_W      = 64;
  localparam int APB_DW     = 64;
  localparam int APB_AW     = 6;

  localparam logic [LEN_W-1:0]  TARGET_LEN_RESET = LEN_W'(1);
  localparam logic [LEN_W-1:0]  REPL_LEN_RESET   = '0;
  localparam logic [BYTE_W-1:0] FILL_CHAR_RESET  = 8'h78;

  typedef enum logic [2:0] {
    RegTargetPattern = 3'd0,
    RegTargetLength  = 3'd1,
    RegReplPattern   = 3'd2,
    RegReplLength    = 3'd3,
    RegFillChar      = 3'd4
  } cfg_reg_e;

endpackage

// ===== src/ssr_stream_if.sv =====
`timescale 1ns / 1ps

interface ssr_in_if;
  import ssr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface ssr_out_if;
  import ssr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              was_replaced;
  logic              out_last;

  modport source (output valid, out_byte, was_replaced, out_last, input ready);
  modport sink (input valid, out_byte, was_replaced, out_last, output ready);
endinterface

// ===== src/stream_string_redactor_top.sv =====
`timescale 1ns / 1ps
// Output: a byte goes from the window to the output register once the request that pushes it
// out of the window is accepted, which is target length minus one requests after its own.
// Throughput, while the output is taken: one request per cycle in the stream; a final request
// drains the window at one byte per cycle through the single output register.
// Reset: asynchronous and active low; it restores the register defaults, empties the window
// and drops output valid.
module stream_string_redactor_top #(
  parameter int MaxTarget = ssr_pkg::MAX_TARGET
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ssr_pkg::APB_AW-1:0] paddr,
  input  logic [ssr_pkg::APB_DW-1:0] pwdata,
  output logic [ssr_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  ssr_in_if.sink                    in_if,
  ssr_out_if.source                 out_if
);
  import ssr_pkg::*;

  localparam int FW = $clog2(MaxTarget + 1);
  localparam int IW = (MaxTarget > 1) ? $clog2(MaxTarget) : 1;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MaxTarget);

  logic [PAT_W-1:0]  target_q, repl_q;
  logic [LEN_W-1:0]  tlen_q, rlen_q;
  logic [BYTE_W-1:0] fill_char_q;
  cfg_reg_e          reg_sel;
  logic              cfg_wr;

  logic [BYTE_W-1:0] win_q [MaxTarget];
  logic [BYTE_W-1:0] win_d [MaxTarget];
  logic              mark_q [MaxTarget];
  logic              mark_d [MaxTarget];
  logic [FW-1:0]     fill_q, fill_d;
  logic [FW-1:0]     skip_q, skip_d;
  logic              flush_q, flush_d;
  logic              busy_q, busy_d;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_mark_q;
  logic              out_last_q;

  logic [LEN_W-1:0]  len4, rlen4;
  logic [FW-1:0]     len;
  logic              work, can_load, do_emit, hit, in_accept, pending;
  logic [BYTE_W-1:0] wb [MaxTarget];
  logic              mk [MaxTarget];
  logic [BYTE_W-1:0] win_s1 [MaxTarget];
  logic              mark_s1 [MaxTarget];
  logic [FW-1:0]     fill_s1, skip_s1;
  logic              flush_s1;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      tlen_q      <= TARGET_LEN_RESET;
      repl_q      <= '0;
      rlen_q      <= REPL_LEN_RESET;
      fill_char_q <= FILL_CHAR_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        RegTargetPattern: target_q    <= pwdata[PAT_W-1:0];
        RegTargetLength:  tlen_q      <= pwdata[LEN_W-1:0];
        RegReplPattern:   repl_q      <= pwdata[PAT_W-1:0];
        RegReplLength:    rlen_q      <= pwdata[LEN_W-1:0];
        RegFillChar:      fill_char_q <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegTargetPattern: prdata = APB_DW'(target_q);
      RegTargetLength:  prdata = APB_DW'(tlen_q);
      RegReplPattern:   prdata = APB_DW'(repl_q);
      RegReplLength:    prdata = APB_DW'(rlen_q);
      RegFillChar:      prdata = APB_DW'(fill_char_q);
      default:          prdata = '0;
    endcase
  end

  // Effective lengths
  always_comb begin
    if (tlen_q == '0) begin
      len4 = LEN_W'(1);
    end else if (tlen_q > MaxLen) begin
      len4 = MaxLen;
    end else begin
      len4 = tlen_q;
    end
    rlen4 = (rlen_q > len4) ? len4 : rlen_q;
    len   = len4[FW-1:0];
  end

  // One check-and-emit step on the window
  assign work     = busy_q && ((fill_q >= len) || (flush_q && fill_q != '0));
  assign can_load = !out_valid_q || out_if.ready;
  assign do_emit  = work && can_load;

  always_comb begin
    logic all_ok;
    all_ok = 1'b1;
    for (int k = 0; k < MaxTarget; k++) begin
      if ((LEN_W'(k) < len4) && (win_q[k] != target_q[8*k +: 8])) begin
        all_ok = 1'b0;
      end
    end
    hit = (skip_q == '0) && (fill_q >= len) && all_ok;
    for (int k = 0; k < MaxTarget; k++) begin
      if (hit && (LEN_W'(k) < len4)) begin
        wb[k] = (LEN_W'(k) < rlen4) ? repl_q[8*k +: 8] : fill_char_q;
        mk[k] = 1'b1;
      end else begin
        wb[k] = win_q[k];
        mk[k] = mark_q[k];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MaxTarget; i++) begin
      if (do_emit && (i < MaxTarget - 1)) begin
        win_s1[i]  = wb[(i + 1) % MaxTarget];
        mark_s1[i] = mk[(i + 1) % MaxTarget];
      end else begin
        win_s1[i]  = win_q[i];
        mark_s1[i] = mark_q[i];
      end
    end
    if (do_emit) begin
      fill_s1 = fill_q - FW'(1);
      if (hit) begin
        skip_s1 = len - FW'(1);
      end else if (skip_q != '0) begin
        skip_s1 = skip_q - FW'(1);
      end else begin
        skip_s1 = '0;
      end
    end else begin
      fill_s1 = fill_q;
      skip_s1 = skip_q;
    end
    flush_s1 = flush_q;
    if (flush_q && fill_s1 == '0) begin
      flush_s1 = 1'b0;
      skip_s1  = '0;
    end
  end

  assign pending     = busy_q && ((fill_s1 >= len) || (flush_s1 && fill_s1 != '0));
  assign in_if.ready = !pending;
  assign in_accept   = in_if.valid && in_if.ready;
  assign busy_d      = in_accept || pending;

  always_comb begin
    for (int i = 0; i < MaxTarget; i++) begin
      win_d[i]  = win_s1[i];
      mark_d[i] = mark_s1[i];
    end
    fill_d  = fill_s1;
    skip_d  = skip_s1;
    flush_d = flush_s1;
    if (in_accept) begin
      win_d[fill_s1[IW-1:0]]  = in_if.in_byte;
      mark_d[fill_s1[IW-1:0]] = 1'b0;
      fill_d  = fill_s1 + FW'(1);
      flush_d = in_if.in_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      skip_q      <= '0;
      flush_q     <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      skip_q  <= skip_d;
      flush_q <= flush_d;
      busy_q  <= busy_d;
      if (can_load) begin
        out_valid_q <= do_emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxTarget; i++) begin
      win_q[i]  <= win_d[i];
      mark_q[i] <= mark_d[i];
    end
    if (do_emit) begin
      out_byte_q <= wb[0];
      out_mark_q <= mk[0];
      out_last_q <= flush_q && (fill_q == FW'(1));
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.out_byte     = out_byte_q;
  assign out_if.was_replaced = out_mark_q;
  assign out_if.out_last     = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FW'(MaxTarget))
    else $error("Window holds more bytes than it has room for.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) skip_q <= fill_q)
    else $error("More bytes are marked for skipping than the window holds.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_if.ready |-> busy_q)
    else $error("Input is held off although no request is in progress.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !out_if.ready) |=> !do_emit || out_if.ready)
    else $error("A new byte was loaded over one that had not been taken.");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ssr_pkg::*;

  localparam int BadRegIdx     = 5;
  localparam int LastBadRegIdx = 7;
  localparam int DirectedItems = 22;
  localparam int RandomItems   = 330;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              replaced;
    logic              last;
  } redacted_byte_t;

  class redaction_scoreboard;
    logic [PAT_W-1:0]  tgt_pattern;
    logic [LEN_W-1:0]  tgt_len;
    logic [PAT_W-1:0]  repl_pattern;
    logic [LEN_W-1:0]  repl_len;
    logic [BYTE_W-1:0] fill_byte;
    logic [BYTE_W-1:0] win_bytes [MAX_TARGET];
    bit                win_marks [MAX_TARGET];
    int                win_fill;
    int                skip_cnt;
    int                err_count;
    redacted_byte_t    expected_bytes [$];

    function new();
      tgt_pattern  = '0;
      tgt_len      = TARGET_LEN_RESET;
      repl_pattern = '0;
      repl_len     = REPL_LEN_RESET;
      fill_byte    = FILL_CHAR_RESET;
      foreach (win_bytes[i]) begin
        win_bytes[i] = '0;
        win_marks[i] = 1'b0;
      end
      win_fill  = 0;
      skip_cnt  = 0;
      err_count = 0;
    endfunction

    function void write_reg(int idx, logic [APB_DW-1:0] value);
      case (idx)
        RegTargetPattern: tgt_pattern  = value;
        RegTargetLength:  tgt_len      = value[LEN_W-1:0];
        RegReplPattern:   repl_pattern = value;
        RegReplLength:    repl_len     = value[LEN_W-1:0];
        RegFillChar:      fill_byte    = value[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function int match_len();
      if (tgt_len == 0) return 1;
      if (tgt_len > MAX_TARGET) return MAX_TARGET;
      return int'(tgt_len);
    endfunction

    function void push_oldest();
      redacted_byte_t item;
      item.data     = win_bytes[0];
      item.replaced = win_marks[0];
      item.last     = 1'b0;
      expected_bytes.push_back(item);
      for (int i = 1; i < win_fill; i++) begin
        win_bytes[i-1] = win_bytes[i];
        win_marks[i-1] = win_marks[i];
      end
      if (win_fill > 0) win_fill--;
      if (skip_cnt > 0) skip_cnt--;
    endfunction

    function void note_request(logic [BYTE_W-1:0] b, logic last);
      int  len;
      int  rlen;
      int  produced;
      bit  hit;
      len      = match_len();
      rlen     = int'(repl_len);
      produced = expected_bytes.size();
      if (rlen > len) rlen = len;
      if (win_fill >= MAX_TARGET) push_oldest();
      win_bytes[win_fill] = b;
      win_marks[win_fill] = 1'b0;
      win_fill++;
      while (win_fill >= len) begin
        if (skip_cnt == 0) begin
          hit = 1'b1;
          for (int k = 0; k < len; k++) begin
            if (win_bytes[k] != tgt_pattern[8*k +: 8]) hit = 1'b0;
          end
          if (hit) begin
            for (int k = 0; k < len; k++) begin
              win_bytes[k] = (k < rlen) ? repl_pattern[8*k +: 8] : fill_byte;
              win_marks[k] = 1'b1;
            end
            skip_cnt = len;
          end
        end
        push_oldest();
      end
      if (last) begin
        while (win_fill > 0) push_oldest();
        skip_cnt = 0;
        if (expected_bytes.size() > produced) begin
          expected_bytes[expected_bytes.size()-1].last = 1'b1;
        end
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_count++;
    endtask

    task check_byte(logic [BYTE_W-1:0] data, logic replaced, logic last);
      redacted_byte_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h (replaced %0b, last %0b)", data, replaced, last));
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        report($sformatf("out_byte %02h, wanted %02h", data, want.data));
      end
      if (replaced !== want.replaced) begin
        report($sformatf("was_replaced %0b, wanted %0b", replaced, want.replaced));
      end
      if (last !== want.last) begin
        report($sformatf("out_last %0b, wanted %0b", last, want.last));
      end
    endtask

    task flag_leftovers();
      if (expected_bytes.size() != 0) begin
        report($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
      end
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ssr_in_if  in_if ();
  ssr_out_if out_if ();

  stream_string_redactor_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (in_if),
    .out_if  (out_if)
  );

  redaction_scoreboard sb = new();

  bit                calm;
  int                items_sent;
  logic [PAT_W-1:0]  tgt_word;
  int                tgt_eff;
  logic [BYTE_W-1:0] sym_a;
  logic [BYTE_W-1:0] sym_b;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_byte(out_if.out_byte, out_if.was_replaced, out_if.out_last);
      end
      if (in_if.valid && in_if.ready) begin
        sb.note_request(in_if.in_byte, in_if.in_last);
      end
    end
  end

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int run;
    int gap;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 40);
      out_if.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = idle_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(int idx, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx * 8);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [PAT_W-1:0] tp, logic [LEN_W-1:0] tl,
                            logic [PAT_W-1:0] rp, logic [LEN_W-1:0] rl,
                            logic [BYTE_W-1:0] fc);
    logic [APB_DW-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
    write_reg(RegTargetPattern, tp);
    write_reg(RegTargetLength, {junk[APB_DW-1:LEN_W], tl});
    write_reg(RegReplPattern, rp);
    write_reg(RegReplLength, {junk[APB_DW-1:LEN_W], rl});
    write_reg(RegFillChar, {junk[APB_DW-1:BYTE_W], fc});
    tgt_word = tp;
    tgt_eff  = (tl == 0) ? 1 : ((tl > MAX_TARGET) ? MAX_TARGET : int'(tl));
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic configure_random();
    logic [PAT_W-1:0]  tp;
    logic [LEN_W-1:0]  tl;
    logic [BYTE_W-1:0] fc;
    int                pick;
    sym_a = BYTE_W'($urandom);
    sym_b = ($urandom_range(0, 5) == 0) ? sym_a : BYTE_W'($urandom);
    pick  = $urandom_range(0, 9);
    if (pick == 0) begin
      tl = $urandom_range(0, 1) ? LEN_W'(0) : LEN_W'($urandom_range(9, 15));
    end else if (pick < 3) begin
      tl = LEN_W'(MAX_TARGET);
    end else if (pick < 5) begin
      tl = LEN_W'(1);
    end else begin
      tl = LEN_W'($urandom_range(1, MAX_TARGET));
    end
    for (int k = 0; k < MAX_TARGET; k++) begin
      if ($urandom_range(0, 9) == 0) tp[8*k +: 8] = BYTE_W'($urandom);
      else tp[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
    end
    pick = $urandom_range(0, 5);
    fc   = (pick == 0) ? 8'h00 : ((pick == 1) ? 8'hff : BYTE_W'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      write_reg($urandom_range(BadRegIdx, LastBadRegIdx), {$urandom, $urandom});
    end
    set_config(tp, tl, {$urandom, $urandom}, LEN_W'($urandom_range(0, 15)), fc);
  endtask

  task automatic send_phase(int count, bit close_stream);
    logic [BYTE_W-1:0] stream [$];
    int                r;
    int                n;
    while (stream.size() < count) begin
      r = $urandom_range(0, 9);
      if (r < 4 || (r < 6 && tgt_eff == 1)) begin
        for (int k = 0; k < tgt_eff; k++) stream.push_back(tgt_word[8*k +: 8]);
      end else if (r < 6) begin
        n = $urandom_range(1, tgt_eff - 1);
        for (int k = 0; k < n; k++) stream.push_back(tgt_word[8*k +: 8]);
      end else if (r < 9) begin
        stream.push_back($urandom_range(0, 1) ? sym_a : sym_b);
      end else begin
        stream.push_back(BYTE_W'($urandom));
      end
    end
    for (int i = 0; i < count; i++) begin
      send_byte(stream[i], (close_stream && i == count - 1) || $urandom_range(0, 49) == 0);
    end
  endtask

  initial begin
    int drain_cnt;
    logic [PAT_W-1:0] pat;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= '0;
    in_if.in_last <= 1'b0;
    calm          = 1'b0;
    items_sent    = 0;
    tgt_word      = '0;
    tgt_eff       = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: a zero byte matches and becomes the fill character.
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();

    // Overlapping prefix, and a copy that ends on the final byte.
    set_config(64'h6261, 4'd2, 64'h5a, 4'd1, 8'h2a);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
    wait_idle();

    // Longest target of all ones, replacement length beyond the target length.
    set_config('1, 4'd15, 64'h0011_2233_4455_6677, 4'd15, 8'h00);
    for (int i = 0; i < MAX_TARGET; i++) send_byte(8'hff, i == MAX_TARGET - 1);
    wait_idle();

    // Target length shrinks while the window still holds bytes.
    pat = {$urandom, $urandom};
    set_config(pat, 4'd8, '0, 4'd0, 8'hff);
    for (int i = 0; i < 5; i++) send_byte(pat[8*i +: 8], 1'b0);
    wait_idle();
    write_reg(BadRegIdx, '1);
    set_config(64'h41, 4'd0, 64'h7e, 4'd8, 8'hff);
    send_byte(8'h41, 1'b1);
    wait_idle();

    while (items_sent < DirectedItems + RandomItems) begin
      configure_random();
      calm = ($urandom_range(0, 3) == 0);
      send_phase($urandom_range(20, 60), $urandom_range(0, 4) != 0);
      wait_idle();
    end

    drain_cnt = 0;
    while (sb.pending() != 0 && drain_cnt < 20000) begin
      @(posedge clk_i);
      drain_cnt++;
    end
    repeat (20) @(posedge clk_i);
    sb.flag_leftovers();
    if (sb.err_count == 0) begin
      $display("stream_string_redactor_top verification clean");
    end else begin
      $display("stream_string_redactor_top verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("stream_string_redactor_top verification failed");
    $finish;
  end

endmodule
